FILE: sv/ffag_pkg.sv
// Package for the first-fit aligned gap finder.
// Holds default parameter values and the opcode, register index and status codes.
// Used by the top level and by its checker.
package ffag_pkg;

    localparam int PAGE_SIZE_DEF = 4096;
    localparam int ADDR_BITS_DEF = 48;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_REGION  = 1'b1;

    localparam logic CFG_MIN_VA = 1'b0;
    localparam logic CFG_MAX_VA = 1'b1;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_NO_SPACE = 1'b1;

endpackage

FILE: sv/first_fit_aligned_gap_finder_top.sv
// Top level of the first-fit aligned gap finder: input register, gap test and result register.
// Depends on ffag_pkg for parameter defaults and codes.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     opcode, object_size, alignment,
//                                               region_base, region_size, last_region
//   out      output     out_valid / out_ready   placed_address, status
//   cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per cycle while the input does not stall: an item is held in the input register
// and evaluated there by the rounding adders and gap compares in a single pass.
// A last region is taken into the input register and its result is then written to the output register.
// The input stalls only while a result waits in the output register and the
// next item in the input register is also a last region.
// Reset puts all control state to its idle values; configuration writes are always taken.
module first_fit_aligned_gap_finder_top
    import ffag_pkg::*;
#(
    parameter int PAGE_SIZE = PAGE_SIZE_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 opcode,
    input  logic [ADDR_BITS-1:0] object_size,
    input  logic [ADDR_BITS-1:0] alignment,
    input  logic [ADDR_BITS-1:0] region_base,
    input  logic [ADDR_BITS-1:0] region_size,
    input  logic                 last_region,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_BITS-1:0] placed_address,
    output logic                 status,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [ADDR_BITS-1:0] cfg_data
);

    localparam int AW = ADDR_BITS;
    localparam int SW = ADDR_BITS + 4;

    typedef logic [SW-1:0] wide_t;

    function automatic wide_t align_up(wide_t x, wide_t a);
        wide_t m;
        m = a - wide_t'(1);
        if (a == '0)
        begin
            return x;
        end
        return (x + m) & ~m;
    endfunction

    localparam wide_t PAGE_W = wide_t'(PAGE_SIZE);

    logic [AW-1:0] min_va_reg;
    logic [AW-1:0] max_va_reg;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic          s1_op_reg;
    logic [AW-1:0] s1_size_reg;
    logic [AW-1:0] s1_align_reg;
    logic [AW-1:0] s1_base_reg;
    logic [AW-1:0] s1_rsize_reg;
    logic          s1_last_reg;

    logic [AW-1:0] raw_size_reg;
    logic [AW-1:0] raw_size_next;
    logic [AW:0]   align_reg;
    logic [AW:0]   align_next;
    logic [AW+1:0] rounded_reg;
    logic [AW+1:0] rounded_next;
    logic [AW+2:0] end_reg;
    logic [AW+2:0] end_next;
    logic [AW+2:0] chosen_reg;
    logic [AW+2:0] chosen_next;
    logic          have_reg;
    logic          have_next;
    logic          first_reg;
    logic          first_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [AW-1:0] placed_reg;
    logic [AW-1:0] placed_next;
    logic          status_reg;
    logic          status_next;

    logic          in_accept;
    logic          s1_produce;
    logic          s1_fire;

    wide_t         req_align;
    wide_t         req_rounded;
    wide_t         minva;
    wide_t         reg_end;
    wide_t         gap_addr;
    wide_t         final_addr;
    logic          gap_ok;
    logic          no_space;

    assign cfg_ready  = 1'b1;
    assign in_accept  = in_valid && in_ready;
    assign s1_produce = s1_valid_reg && (s1_op_reg == OP_REGION) && s1_last_reg;
    assign s1_fire    = s1_valid_reg && (!s1_produce || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_va_reg <= '0;
            max_va_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MIN_VA: min_va_reg <= cfg_data;
                CFG_MAX_VA: max_va_reg <= cfg_data;
                default:    min_va_reg <= min_va_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg    <= opcode;
            s1_size_reg  <= object_size;
            s1_align_reg <= alignment;
            s1_base_reg  <= region_base;
            s1_rsize_reg <= region_size;
            s1_last_reg  <= last_region;
        end
    end

    always_comb
    begin
        req_align = (s1_align_reg == '0) ? PAGE_W : align_up(wide_t'(s1_align_reg), PAGE_W);
        req_rounded = align_up(wide_t'(s1_size_reg), wide_t'(req_align[AW:0]));

        minva   = align_up(wide_t'(min_va_reg), wide_t'(align_reg));
        reg_end = align_up(wide_t'(s1_base_reg) + align_up(wide_t'(s1_rsize_reg), PAGE_W),
                           wide_t'(align_reg));

        if (first_reg)
        begin
            gap_ok   = (minva + wide_t'(rounded_reg)) <= wide_t'(s1_base_reg);
            gap_addr = minva;
        end
        else
        begin
            gap_ok   = wide_t'(s1_base_reg) > (wide_t'(end_reg) + wide_t'(rounded_reg));
            gap_addr = wide_t'(end_reg);
        end

        raw_size_next = raw_size_reg;
        align_next    = align_reg;
        rounded_next  = rounded_reg;
        end_next      = end_reg;
        chosen_next   = chosen_reg;
        have_next     = have_reg;
        first_next    = first_reg;

        if (!have_reg && gap_ok)
        begin
            final_addr = gap_addr;
        end
        else if (have_reg)
        begin
            final_addr = wide_t'(chosen_reg);
        end
        else
        begin
            final_addr = reg_end;
        end
        no_space    = (final_addr + wide_t'(raw_size_reg)) > wide_t'(max_va_reg);
        placed_next = no_space ? '0 : final_addr[AW-1:0];
        status_next = no_space ? ST_NO_SPACE : ST_OK;

        if (s1_fire)
        begin
            if (s1_op_reg == OP_REQUEST)
            begin
                raw_size_next = s1_size_reg;
                align_next    = req_align[AW:0];
                rounded_next  = req_rounded[AW+1:0];
                end_next      = '0;
                chosen_next   = '0;
                have_next     = 1'b0;
                first_next    = 1'b1;
            end
            else if (s1_last_reg)
            begin
                end_next    = '0;
                chosen_next = '0;
                have_next   = 1'b0;
                first_next  = 1'b1;
            end
            else
            begin
                end_next   = reg_end[AW+2:0];
                first_next = 1'b0;
                if (!have_reg && gap_ok)
                begin
                    chosen_next = gap_addr[AW+2:0];
                    have_next   = 1'b1;
                end
            end
        end

        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_fire && s1_produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            raw_size_reg  <= '0;
            align_reg     <= (AW+1)'(PAGE_SIZE);
            rounded_reg   <= '0;
            end_reg       <= '0;
            chosen_reg    <= '0;
            have_reg      <= 1'b0;
            first_reg     <= 1'b1;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            raw_size_reg  <= raw_size_next;
            align_reg     <= align_next;
            rounded_reg   <= rounded_next;
            end_reg       <= end_next;
            chosen_reg    <= chosen_next;
            have_reg      <= have_next;
            first_reg     <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_produce)
        begin
            placed_reg <= placed_next;
            status_reg <= status_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign placed_address = placed_reg;
    assign status         = status_reg;

endmodule

FILE: sv/ffag_checker.sv
// Port-level checker for the first-fit aligned gap finder, bound to its top level.
// Depends on ffag_pkg for a parameter default and the opcode and status codes.
module ffag_checker
    import ffag_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 opcode,
    input  logic                 last_region,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [ADDR_BITS-1:0] placed_address,
    input  logic                 status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(placed_address) && $stable(status))
        else $error("Result item changed while stalled.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_NO_SPACE |-> placed_address == '0)
        else $error("Out-of-space result carries a nonzero address.");

    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |->
            $past(in_valid && in_ready && opcode == OP_REGION && last_region, 2))
        else $error("Result item without a preceding last region item.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("Input stalled while no result item is waiting.");

endmodule

bind first_fit_aligned_gap_finder_top ffag_checker #(.ADDR_BITS(ADDR_BITS)) u_ffag_checker (.*);
